@@ sv/cfoc_pkg.sv @@
// Shared types and constants for the chunk frustum and occlusion culler.
package cfoc_pkg;

    localparam int PLANE_COUNT     = 6;
    localparam int AXIS_COUNT      = 3;
    localparam int COORD_W         = 16;
    localparam int PROD_W          = 2 * COORD_W;
    localparam int SUM_W           = PROD_W + 2;
    localparam int D_SHIFT         = 14;
    localparam int CHUNK_W         = 6;
    localparam int HIDDEN_W        = 6;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CHUNK_COUNT_DEF = 64;
    localparam logic [HIDDEN_W-1:0] PROBE_RESET = 6'd30;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLANE_LEFT     = 3'd0,
        REG_PLANE_RIGHT    = 3'd1,
        REG_PLANE_BOTTOM   = 3'd2,
        REG_PLANE_TOP      = 3'd3,
        REG_PLANE_NEAR     = 3'd4,
        REG_PLANE_FAR      = 3'd5,
        REG_OCC_ENABLE     = 3'd6,
        REG_PROBE_INTERVAL = 3'd7
    } cfg_reg_t;

    // One plane: normal in Q2.14, offset in Q8.8
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } plane_t;

    // Occlusion controls
    typedef struct packed {
        logic                occ_enable;
        logic [HIDDEN_W-1:0] probe_interval;
    } occ_cfg_t;

    // Per-chunk state word
    typedef struct packed {
        logic                pending;
        logic                visible;
        logic [HIDDEN_W-1:0] hidden;
    } chunk_state_t;

    localparam chunk_state_t CHUNK_STATE_RESET = '{pending: 1'b0, visible: 1'b1, hidden: '0};

    // Item control at the update stage
    typedef struct packed {
        logic act;
        logic query_available;
        logic query_passed;
    } item_ctl_t;

    // Draw decision for one transaction
    typedef struct packed {
        logic draw;
        logic start_query;
    } verdict_t;

endpackage

@@ sv/chunk_frustum_occlusion_culler_top.sv @@
// Top level of the chunk frustum and occlusion culler.
// A transaction that is taken passes the input register, the product register and the result
// register in that order before its result strobe goes high.
// Throughput: one transaction per cycle while busy is low; per-chunk state is a read-modify-write with
// forwarding of the last write. The receiver cannot stall; results are never held.
// Reset: busy stays high for CHUNK_COUNT cycles while the state RAM is cleared.
module chunk_frustum_occlusion_culler_top #(
    parameter int CHUNK_COUNT = cfoc_pkg::CHUNK_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cfoc_pkg::CHUNK_W-1:0]      chunk_index,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_min_x,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_min_y,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_min_z,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_max_x,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_max_y,
    input  logic signed [cfoc_pkg::COORD_W-1:0] box_max_z,
    input  logic                              query_available,
    input  logic                              query_passed,
    input  logic                              cfg_we,
    input  logic [cfoc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cfoc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              result_valid,
    output logic                              in_frustum,
    output logic                              draw,
    output logic                              start_query
);
    import cfoc_pkg::*;

    localparam int ADDR_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int CMP_W  = ((ADDR_W > CHUNK_W) ? ADDR_W : CHUNK_W) + 1;

    plane_t [PLANE_COUNT-1:0] planes;
    occ_cfg_t                 occ_cfg;

    logic                                   accept;
    logic                                   clearing;

    // Input stage
    logic                                   s1_valid_reg;
    logic [CHUNK_W-1:0]                     s1_index_reg;
    logic [AXIS_COUNT-1:0][COORD_W-1:0]     s1_min_reg;
    logic [AXIS_COUNT-1:0][COORD_W-1:0]     s1_max_reg;
    logic                                   s1_qa_reg;
    logic                                   s1_qp_reg;
    logic [CMP_W-1:0]                       s1_index_wide;
    logic                                   s1_in_range;
    logic [ADDR_W-1:0]                      s1_addr;

    // Update stage
    logic                                   s2_valid_reg;
    logic                                   s2_in_range_reg;
    logic [ADDR_W-1:0]                      s2_addr_reg;
    logic                                   s2_qa_reg;
    logic                                   s2_qp_reg;
    logic                                   s2_inside;
    item_ctl_t                              s2_ctl;
    verdict_t                               s2_verdict;

    // Result stage
    logic                                   result_valid_reg;
    logic                                   in_frustum_reg;
    logic                                   draw_reg;
    logic                                   start_query_reg;

    assign busy   = clearing;
    assign accept = start && !busy;

    cfoc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes),
        .occ_cfg   (occ_cfg)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_index_reg <= chunk_index;
            s1_min_reg   <= {box_min_z, box_min_y, box_min_x};
            s1_max_reg   <= {box_max_z, box_max_y, box_max_x};
            s1_qa_reg    <= query_available;
            s1_qp_reg    <= query_passed;
        end
    end

    // Chunk range check and state address
    assign s1_index_wide = CMP_W'(s1_index_reg);
    assign s1_in_range   = s1_index_wide < CMP_W'(CHUNK_COUNT);
    assign s1_addr       = s1_index_wide[ADDR_W-1:0];

    cfoc_frustum u_frustum (
        .clk     (clk),
        .planes  (planes),
        .box_min (s1_min_reg),
        .box_max (s1_max_reg),
        .box_in  (s2_inside)
    );

    // Update-stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_in_range_reg <= s1_in_range;
        s2_addr_reg     <= s1_addr;
        s2_qa_reg       <= s1_qa_reg;
        s2_qp_reg       <= s1_qp_reg;
    end

    assign s2_ctl.act             = s2_valid_reg && s2_inside && s2_in_range_reg;
    assign s2_ctl.query_available = s2_qa_reg;
    assign s2_ctl.query_passed    = s2_qp_reg;

    cfoc_state #(
        .CHUNK_COUNT (CHUNK_COUNT)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (s1_addr),
        .upd_addr (s2_addr_reg),
        .upd_ctl  (s2_ctl),
        .occ_cfg  (occ_cfg),
        .verdict  (s2_verdict),
        .clearing (clearing)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_frustum_reg  <= s2_inside;
        draw_reg        <= s2_verdict.draw;
        start_query_reg <= s2_verdict.start_query;
    end

    assign result_valid = result_valid_reg;
    assign in_frustum   = in_frustum_reg;
    assign draw         = draw_reg;
    assign start_query  = start_query_reg;

endmodule

@@ sv/cfoc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/cfoc_cfg_regs.sv @@
// Configuration registers: six frustum planes and occlusion controls.
module cfoc_cfg_regs (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [cfoc_pkg::CFG_INDEX_W-1:0]              cfg_index,
    input  logic [cfoc_pkg::CFG_DATA_W-1:0]               cfg_data,
    output cfoc_pkg::plane_t [cfoc_pkg::PLANE_COUNT-1:0]  planes,
    output cfoc_pkg::occ_cfg_t                            occ_cfg
);
    import cfoc_pkg::*;

    plane_t [PLANE_COUNT-1:0] planes_reg;
    occ_cfg_t                 occ_cfg_reg;

    // Register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg  <= '0;
            occ_cfg_reg <= '{occ_enable: 1'b0, probe_interval: PROBE_RESET};
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PLANE_LEFT:     planes_reg[0] <= cfg_data;
                REG_PLANE_RIGHT:    planes_reg[1] <= cfg_data;
                REG_PLANE_BOTTOM:   planes_reg[2] <= cfg_data;
                REG_PLANE_TOP:      planes_reg[3] <= cfg_data;
                REG_PLANE_NEAR:     planes_reg[4] <= cfg_data;
                REG_PLANE_FAR:      planes_reg[5] <= cfg_data;
                REG_OCC_ENABLE:     occ_cfg_reg.occ_enable <= cfg_data[0];
                REG_PROBE_INTERVAL: occ_cfg_reg.probe_interval <= cfg_data[HIDDEN_W-1:0];
                default:            occ_cfg_reg <= occ_cfg_reg;
            endcase
        end
    end

    assign planes  = planes_reg;
    assign occ_cfg = occ_cfg_reg;

endmodule

@@ sv/cfoc_frustum.sv @@
// Positive-vertex box test against six planes: product stage, then sum and sign.
module cfoc_frustum (
    input  logic                                                     clk,
    input  cfoc_pkg::plane_t [cfoc_pkg::PLANE_COUNT-1:0]             planes,
    input  logic [cfoc_pkg::AXIS_COUNT-1:0][cfoc_pkg::COORD_W-1:0]   box_min,
    input  logic [cfoc_pkg::AXIS_COUNT-1:0][cfoc_pkg::COORD_W-1:0]   box_max,
    output logic                                                     box_in
);
    import cfoc_pkg::*;

    logic signed [PROD_W-1:0]  prod_reg [PLANE_COUNT][AXIS_COUNT];
    logic signed [COORD_W-1:0] d_reg    [PLANE_COUNT];
    logic signed [COORD_W-1:0] normal   [PLANE_COUNT][AXIS_COUNT];
    logic signed [COORD_W-1:0] vertex   [PLANE_COUNT][AXIS_COUNT];
    logic signed [SUM_W-1:0]   sum      [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]    outside;

    // Pick the positive vertex per axis
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            normal[p][0] = planes[p].nx;
            normal[p][1] = planes[p].ny;
            normal[p][2] = planes[p].nz;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                vertex[p][a] = normal[p][a][COORD_W-1] ? $signed(box_min[a])
                                                       : $signed(box_max[a]);
            end
        end
    end

    // Eighteen products, registered
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            d_reg[p] <= planes[p].d;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                prod_reg[p][a] <= normal[p][a] * vertex[p][a];
            end
        end
    end

    // Exact Q.22 sum per plane; negative means outside
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            sum[p] = SUM_W'(prod_reg[p][0]) + SUM_W'(prod_reg[p][1])
                   + SUM_W'(prod_reg[p][2])
                   + SUM_W'($signed({d_reg[p], {D_SHIFT{1'b0}}}));
            outside[p] = sum[p][SUM_W-1];
        end
    end

    assign box_in = ~|outside;

endmodule

@@ sv/cfoc_state.sv @@
// Per-chunk occlusion state: RAM, clearing pass after reset, read-modify-write.
module cfoc_state #(
    parameter int CHUNK_COUNT = cfoc_pkg::CHUNK_COUNT_DEF,
    localparam int ADDR_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [ADDR_W-1:0]   upd_addr,
    input  cfoc_pkg::item_ctl_t upd_ctl,
    input  cfoc_pkg::occ_cfg_t  occ_cfg,
    output cfoc_pkg::verdict_t  verdict,
    output logic                clearing
);
    import cfoc_pkg::*;

    localparam int STATE_W = $bits(chunk_state_t);

    logic               clear_active_reg;
    logic               clear_active_next;
    logic [ADDR_W-1:0]  clear_addr_reg;
    logic [ADDR_W-1:0]  clear_addr_next;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    chunk_state_t       fwd_data_reg;

    logic [STATE_W-1:0] ram_rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [STATE_W-1:0] ram_wdata;

    chunk_state_t       cur;
    chunk_state_t       upd;
    logic [HIDDEN_W-1:0] hidden_inc;
    logic               go;

    cfoc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHUNK_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Clearing sweep, one entry a cycle
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            if (clear_addr_reg == ADDR_W'(CHUNK_COUNT - 1))
            begin
                clear_active_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            fwd_valid_reg    <= upd_ctl.act;
        end
    end

    // Last write, for an item that read the same entry at that edge
    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= upd_addr;
        fwd_data_reg <= upd;
    end

    // State update for one visit
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == upd_addr))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = chunk_state_t'(ram_rdata);
        end

        upd        = cur;
        go         = 1'b1;
        hidden_inc = cur.hidden + 1'b1;

        if (cur.pending && upd_ctl.query_available)
        begin
            upd.visible = upd_ctl.query_passed;
            upd.pending = 1'b0;
        end

        if (!upd.visible)
        begin
            if (hidden_inc < occ_cfg.probe_interval)
            begin
                upd.hidden = hidden_inc;
                go         = 1'b0;
            end
            else
            begin
                upd.visible = 1'b1;
                upd.hidden  = '0;
            end
        end

        if (go && occ_cfg.occ_enable)
        begin
            upd.pending = 1'b1;
        end

        verdict.draw        = upd_ctl.act && go;
        verdict.start_query = upd_ctl.act && go && occ_cfg.occ_enable;
    end

    // Write port: clearing sweep or item update
    always_comb
    begin
        if (clear_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = CHUNK_STATE_RESET;
        end
        else
        begin
            ram_we    = upd_ctl.act;
            ram_waddr = upd_addr;
            ram_wdata = upd;
        end
    end

    assign clearing = clear_active_reg;

endmodule
